[design/mswd_pkg.sv]
// Shared types, constants and helpers for the multi-source watchdog monitor.
// Depends on nothing; every other design file imports it.
package mswd_pkg;

    // Source table size and derived index width
    localparam int SOURCES     = 8;
    localparam int SRC_W       = (SOURCES > 1) ? $clog2(SOURCES) : 1;

    // Field widths
    localparam int OP_W        = 2;
    localparam int SOURCE_W    = 4;
    localparam int TIME_W      = 32;
    localparam int INTERVAL_W  = 31;
    localparam int STATUS_W    = 2;

    // First invalid source index, one bit wider than the source field
    localparam logic [SOURCE_W:0] SRC_LIMIT = (SOURCE_W + 1)'(SOURCES);
    localparam logic [SRC_W-1:0]  SRC_LAST  = SRC_W'(SOURCES - 1);

    // Patrol interval used when no source is registered (half the hard cap)
    localparam logic [TIME_W-1:0]     HARD_CAP_MS     = TIME_W'(10000);
    localparam logic [INTERVAL_W-1:0] DEFAULT_PATROL  = HARD_CAP_MS[TIME_W-1:1];

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_FEED     = 2'd1,
        OP_START    = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_PARAM = 2'd1,
        ST_STATE = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic scan_step;  // check one table entry this cycle
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;  // accepted tick expires the patrol countdown
        logic scan_hit;   // current entry is overdue
        logic scan_last;  // current entry is the last one
    } dp_status_t;

    // max(1, lowest / 2), or the default when nothing is registered
    function automatic logic [INTERVAL_W-1:0] patrol_interval(
        input logic              any,
        input logic [TIME_W-1:0] lowest
    );
        logic [INTERVAL_W-1:0] half;
        half = lowest[TIME_W-1:1];
        if (!any) begin
            return DEFAULT_PATROL;
        end
        return (half == '0) ? INTERVAL_W'(1) : half;
    endfunction

endpackage

[design/multi_source_watchdog_monitor_unit.sv]
// Multi-source watchdog monitor: top level joining controller and datapath.
// Depends on mswd_pkg, mswd_ctrl and mswd_datapath.
//
// Each input beat (register, feed, start or a one millisecond tick) yields
// exactly one result beat. Register, feed, start and ticks that do not expire
// the patrol countdown finish without a patrol, and a new beat is taken in the
// same cycle the previous result is taken. A tick that expires the countdown
// starts a patrol that checks one source table entry per cycle, stopping at
// the first overdue source or after the last entry; no input is taken during
// the patrol. The patrol interval output reflects the registered periods at
// all times; after a failure is latched, ticks still advance the clock but no
// patrol runs.
module multi_source_watchdog_monitor_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mswd_pkg::OP_W-1:0]           s_operation,
    input  logic [mswd_pkg::SOURCE_W-1:0]       s_source,
    input  logic [mswd_pkg::TIME_W-1:0]         s_period_ms,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mswd_pkg::STATUS_W-1:0]       m_status,
    output logic                                m_overdue,
    output logic [mswd_pkg::SOURCE_W-1:0]       m_overdue_source,
    output logic [mswd_pkg::TIME_W-1:0]         m_overdue_last_feed_ms,
    output logic [mswd_pkg::INTERVAL_W-1:0]     m_patrol_period_ms,
    output logic                                m_failed
);
    import mswd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    mswd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    mswd_datapath u_datapath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .s_operation            (s_operation),
        .s_source               (s_source),
        .s_period_ms            (s_period_ms),
        .dp_status              (dp_status),
        .m_status               (m_status),
        .m_overdue              (m_overdue),
        .m_overdue_source       (m_overdue_source),
        .m_overdue_last_feed_ms (m_overdue_last_feed_ms),
        .m_patrol_period_ms     (m_patrol_period_ms),
        .m_failed               (m_failed)
    );

endmodule

[design/mswd_ctrl.sv]
// Controller for the watchdog monitor: idle/scan sequencing and the
// result beat handshake. Depends on mswd_pkg.
module mswd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  mswd_pkg::dp_status_t dp_status,
    output mswd_pkg::ctrl_cmd_t  cmd
);
    import mswd_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        result_done;

    // State register and result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.accept && dp_status.need_scan) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (dp_status.scan_hit || dp_status.scan_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: take a beat only when the result register is free or draining
    always_comb begin
        s_ready       = 1'b0;
        cmd.accept    = 1'b0;
        cmd.scan_step = 1'b0;
        result_done   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = !m_valid_reg || m_ready;
                cmd.accept  = s_valid && s_ready;
                result_done = cmd.accept && !dp_status.need_scan;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                result_done   = dp_status.scan_hit || dp_status.scan_last;
            end
            default: ;
        endcase
        m_valid_next = result_done || (m_valid_reg && !m_ready);
    end

    assign m_valid = m_valid_reg;

endmodule

[design/mswd_datapath.sv]
// Datapath for the watchdog monitor: clock, source table, patrol countdown,
// entry-per-cycle overdue check and result registers. Depends on mswd_pkg.
module mswd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mswd_pkg::ctrl_cmd_t                 cmd,
    input  logic [mswd_pkg::OP_W-1:0]           s_operation,
    input  logic [mswd_pkg::SOURCE_W-1:0]       s_source,
    input  logic [mswd_pkg::TIME_W-1:0]         s_period_ms,
    output mswd_pkg::dp_status_t                dp_status,
    output logic [mswd_pkg::STATUS_W-1:0]       m_status,
    output logic                                m_overdue,
    output logic [mswd_pkg::SOURCE_W-1:0]       m_overdue_source,
    output logic [mswd_pkg::TIME_W-1:0]         m_overdue_last_feed_ms,
    output logic [mswd_pkg::INTERVAL_W-1:0]     m_patrol_period_ms,
    output logic                                m_failed
);
    import mswd_pkg::*;

    // Source table
    logic [TIME_W-1:0]     period_reg [SOURCES];
    logic [TIME_W-1:0]     feed_reg   [SOURCES];
    logic [SOURCES-1:0]    registered_reg, registered_next;

    // Control state
    logic [TIME_W-1:0]     clock_reg, clock_next;
    logic                  running_reg, running_next;
    logic                  fail_reg, fail_next;
    logic [INTERVAL_W-1:0] countdown_reg, countdown_next;
    logic [TIME_W-1:0]     min_period_reg, min_period_next;
    logic                  any_reg, any_next;
    logic [SRC_W-1:0]      scan_ptr_reg, scan_ptr_next;

    // Result payload
    status_t               out_status_reg, out_status_next;
    logic                  out_overdue_reg, out_overdue_next;
    logic [SOURCE_W-1:0]   out_src_reg, out_src_next;
    logic [TIME_W-1:0]     out_feed_reg, out_feed_next;

    op_t                   op;
    logic                  src_valid;
    logic [SRC_W-1:0]      idx;
    logic                  reg_we, feed_we;
    logic [INTERVAL_W-1:0] interval;
    logic [TIME_W-1:0]     scan_diff;
    logic                  scan_hit, scan_last;

    assign op        = op_t'(s_operation);
    assign src_valid = {1'b0, s_source} < SRC_LIMIT;
    assign idx       = s_source[SRC_W-1:0];
    assign interval  = patrol_interval(any_reg, min_period_reg);

    // One table entry checked per scan cycle
    assign scan_diff = clock_reg - feed_reg[scan_ptr_reg];
    assign scan_hit  = registered_reg[scan_ptr_reg] && (scan_diff > period_reg[scan_ptr_reg]);
    assign scan_last = scan_ptr_reg == SRC_LAST;

    assign dp_status.need_scan = (op == OP_TICK) && running_reg && !fail_reg
                                 && (countdown_reg <= INTERVAL_W'(1));
    assign dp_status.scan_hit  = scan_hit;
    assign dp_status.scan_last = scan_last;

    // Item and scan step updates
    always_comb begin
        clock_next       = clock_reg;
        running_next     = running_reg;
        fail_next        = fail_reg;
        countdown_next   = countdown_reg;
        min_period_next  = min_period_reg;
        any_next         = any_reg;
        registered_next  = registered_reg;
        scan_ptr_next    = scan_ptr_reg;
        out_status_next  = out_status_reg;
        out_overdue_next = out_overdue_reg;
        out_src_next     = out_src_reg;
        out_feed_next    = out_feed_reg;
        reg_we           = 1'b0;
        feed_we          = 1'b0;

        if (cmd.accept) begin
            out_status_next  = ST_OK;
            out_overdue_next = 1'b0;
            out_src_next     = '0;
            out_feed_next    = '0;
            unique case (op)
                OP_REGISTER: begin
                    if (!src_valid || (s_period_ms == '0) || running_reg) begin
                        out_status_next = ST_PARAM;
                    end else if (registered_reg[idx]) begin
                        out_status_next = ST_STATE;
                    end else begin
                        reg_we               = 1'b1;
                        registered_next[idx] = 1'b1;
                        any_next             = 1'b1;
                        if (!any_reg || (s_period_ms < min_period_reg)) begin
                            min_period_next = s_period_ms;
                        end
                    end
                end
                OP_FEED: begin
                    feed_we = src_valid;
                end
                OP_START: begin
                    if (running_reg) begin
                        out_status_next = ST_STATE;
                    end else begin
                        running_next   = 1'b1;
                        countdown_next = interval;
                    end
                end
                OP_TICK: begin
                    clock_next = clock_reg + TIME_W'(1);
                    if (running_reg && !fail_reg && (countdown_reg != '0)) begin
                        countdown_next = countdown_reg - INTERVAL_W'(1);
                    end
                    scan_ptr_next = '0;
                end
                default: ;
            endcase
        end else if (cmd.scan_step) begin
            scan_ptr_next = scan_ptr_reg + SRC_W'(1);
            if (scan_hit) begin
                fail_next        = 1'b1;
                out_overdue_next = 1'b1;
                out_src_next     = SOURCE_W'(scan_ptr_reg);
                out_feed_next    = feed_reg[scan_ptr_reg];
            end else if (scan_last) begin
                countdown_next = interval;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg      <= '0;
            running_reg    <= 1'b0;
            fail_reg       <= 1'b0;
            countdown_reg  <= '0;
            any_reg        <= 1'b0;
            registered_reg <= '0;
            scan_ptr_reg   <= '0;
        end else begin
            clock_reg      <= clock_next;
            running_reg    <= running_next;
            fail_reg       <= fail_next;
            countdown_reg  <= countdown_next;
            any_reg        <= any_next;
            registered_reg <= registered_next;
            scan_ptr_reg   <= scan_ptr_next;
        end
    end

    // Payload registers and table writes, no reset
    always_ff @(posedge aclk) begin
        min_period_reg  <= min_period_next;
        out_status_reg  <= out_status_next;
        out_overdue_reg <= out_overdue_next;
        out_src_reg     <= out_src_next;
        out_feed_reg    <= out_feed_next;
        if (reg_we) begin
            period_reg[idx] <= s_period_ms;
        end
        if (reg_we || feed_we) begin
            feed_reg[idx] <= clock_reg;
        end
    end

    // Interval and failure flag only change while the result register is refilled
    assign m_status               = out_status_reg;
    assign m_overdue              = out_overdue_reg;
    assign m_overdue_source       = out_src_reg;
    assign m_overdue_last_feed_ms = out_feed_reg;
    assign m_patrol_period_ms     = interval;
    assign m_failed               = fail_reg;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for multi_source_watchdog_monitor_unit.
// Depends on mswd_pkg and the DUT; a scoreboard class predicts each result
// beat from the accepted input beats, and plain tasks drive the handshakes.
`timescale 1ns / 100ps

module tb_top;
    import mswd_pkg::*;

    localparam int RANDOM_BEATS   = 1300;
    localparam int FAIL_PHASE_AT  = 1050;
    localparam int DRAIN_PAUSE_AT = 700;
    localparam int RX_HOLD_AT     = 350;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int END_WAIT_LIMIT = 20000;

    // One result beat, field by field
    typedef struct packed {
        status_t                 status;
        logic                    overdue;
        logic [SOURCE_W-1:0]     src;
        logic [TIME_W-1:0]       feed_stamp;
        logic [INTERVAL_W-1:0]   interval;
        logic                    failed;
    } watchdog_result_t;

    // Predicted watchdog table plus the queue of reports still owed by the DUT
    class watchdog_scoreboard;
        bit [TIME_W-1:0]  clk_ms;
        bit [TIME_W-1:0]  period_tbl [SOURCES];
        bit [TIME_W-1:0]  feed_tbl [SOURCES];
        bit               reg_tbl [SOURCES];
        bit               running;
        bit               fail_seen;
        bit [TIME_W-1:0]  countdown;
        watchdog_result_t expected_reports [$];
        int               errors;

        function new();
            clk_ms    = '0;
            running   = 1'b0;
            fail_seen = 1'b0;
            countdown = '0;
            errors    = 0;
            for (int k = 0; k < SOURCES; k++) begin
                period_tbl[k] = '0;
                feed_tbl[k]   = '0;
                reg_tbl[k]    = 1'b0;
            end
        endfunction

        // Half the shortest registered period, at least 1; default when empty
        function bit [INTERVAL_W-1:0] patrol_for_table();
            bit              any;
            bit [TIME_W-1:0] lowest;
            bit [TIME_W-1:0] half;
            any    = 1'b0;
            lowest = '0;
            for (int k = 0; k < SOURCES; k++) begin
                if (reg_tbl[k] && (!any || period_tbl[k] < lowest)) begin
                    lowest = period_tbl[k];
                    any    = 1'b1;
                end
            end
            if (!any) begin
                lowest = HARD_CAP_MS;
            end
            half = lowest >> 1;
            return (half == '0) ? INTERVAL_W'(1) : half[INTERVAL_W-1:0];
        endfunction

        // Update the table for one accepted beat and queue the report it owes
        function void predict_beat(op_t op, logic [SOURCE_W-1:0] src,
                                   logic [TIME_W-1:0] per);
            watchdog_result_t r;
            bit [TIME_W-1:0]  elapsed;
            bit               valid_src;
            r         = '0;
            r.status  = ST_OK;
            valid_src = (src < SOURCES);
            case (op)
                OP_REGISTER: begin
                    // parameter checks win over the duplicate check
                    if (!valid_src || per == '0 || running) begin
                        r.status = ST_PARAM;
                    end else if (reg_tbl[src]) begin
                        r.status = ST_STATE;
                    end else begin
                        reg_tbl[src]    = 1'b1;
                        period_tbl[src] = per;
                        feed_tbl[src]   = clk_ms;
                    end
                end
                OP_FEED: begin
                    if (valid_src) begin
                        feed_tbl[src] = clk_ms;
                    end
                end
                OP_START: begin
                    if (running) begin
                        r.status = ST_STATE;
                    end else begin
                        running   = 1'b1;
                        countdown = TIME_W'(patrol_for_table());
                    end
                end
                OP_TICK: begin
                    clk_ms = clk_ms + 1;
                    if (running && !fail_seen) begin
                        if (countdown != '0) begin
                            countdown = countdown - 1;
                        end
                        if (countdown == '0) begin
                            // patrol: first overdue source in index order
                            for (int k = 0; k < SOURCES && !r.overdue; k++) begin
                                elapsed = clk_ms - feed_tbl[k];
                                if (reg_tbl[k] && elapsed > period_tbl[k]) begin
                                    r.overdue    = 1'b1;
                                    r.src        = SOURCE_W'(k);
                                    r.feed_stamp = feed_tbl[k];
                                end
                            end
                            if (r.overdue) begin
                                fail_seen = 1'b1;
                            end else begin
                                countdown = TIME_W'(patrol_for_table());
                            end
                        end
                    end
                end
            endcase
            r.interval = patrol_for_table();
            r.failed   = fail_seen;
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [TIME_W-1:0] exp_v,
                                    logic [TIME_W-1:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one accepted result beat with the oldest queued report
        function void check_beat(watchdog_result_t got);
            watchdog_result_t exp_r;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %0h",
                         $time, got);
                errors++;
                return;
            end
            exp_r = expected_reports.pop_front();
            compare_field("status", TIME_W'(exp_r.status), TIME_W'(got.status));
            compare_field("overdue", TIME_W'(exp_r.overdue), TIME_W'(got.overdue));
            compare_field("overdue_source", TIME_W'(exp_r.src), TIME_W'(got.src));
            compare_field("overdue_last_feed_ms", exp_r.feed_stamp, got.feed_stamp);
            compare_field("patrol_period_ms", TIME_W'(exp_r.interval),
                          TIME_W'(got.interval));
            compare_field("failed", TIME_W'(exp_r.failed), TIME_W'(got.failed));
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation;
    logic [SOURCE_W-1:0]   s_source;
    logic [TIME_W-1:0]     s_period_ms;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic                  m_overdue;
    logic [SOURCE_W-1:0]   m_overdue_source;
    logic [TIME_W-1:0]     m_overdue_last_feed_ms;
    logic [INTERVAL_W-1:0] m_patrol_period_ms;
    logic                  m_failed;

    int                 tx_idle_pct = 24;
    int                 rx_idle_pct = 45;
    bit                 rx_hold_go = 1'b0;
    watchdog_scoreboard sb = new();

    multi_source_watchdog_monitor_unit dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_operation            (s_operation),
        .s_source               (s_source),
        .s_period_ms            (s_period_ms),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_status               (m_status),
        .m_overdue              (m_overdue),
        .m_overdue_source       (m_overdue_source),
        .m_overdue_last_feed_ms (m_overdue_last_feed_ms),
        .m_patrol_period_ms     (m_patrol_period_ms),
        .m_failed               (m_failed)
    );

    always #5 aclk = ~aclk;

    // Offer one input beat, with random idle cycles first; returns at the
    // rising edge that accepted it
    task automatic send_item(input op_t op, input logic [SOURCE_W-1:0] src,
                             input logic [TIME_W-1:0] per);
        bit took;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_source    <= src;
        s_period_ms <= per;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
    endtask

    // Stop offering until every owed report has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (12) @(posedge aclk);
    endtask

    // Inputs and outputs are stable at the falling edge, so both handshakes
    // are sampled there; the input is noted before the result is checked
    always @(negedge aclk) begin : beat_monitor
        watchdog_result_t seen;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.predict_beat(op_t'(s_operation), s_source, s_period_ms);
            end
            if (m_valid && m_ready) begin
                seen.status     = status_t'(m_status);
                seen.overdue    = m_overdue;
                seen.src        = m_overdue_source;
                seen.feed_stamp = m_overdue_last_feed_ms;
                seen.interval   = m_patrol_period_ms;
                seen.failed     = m_failed;
                sb.check_beat(seen);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_go) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_go <= 1'b0;
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Stimulus
    initial begin
        int              risk_src;
        int              pick;
        int              w;
        bit [TIME_W-1:0] elapsed;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_TICK;
        s_source    = '0;
        s_period_ms = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: error paths, field extremes, table setup, start twice
        send_item(OP_TICK, 4'd0, 32'h0);
        send_item(OP_FEED, 4'd15, 32'hFFFF_FFFF);     // invalid index is ignored
        send_item(OP_FEED, 4'd1, 32'h0);              // unregistered valid source
        send_item(OP_REGISTER, 4'd8, 32'd5);          // bad index
        send_item(OP_REGISTER, 4'd15, 32'hFFFF_FFFF); // bad index, max period
        send_item(OP_REGISTER, 4'd3, 32'h0);          // zero period
        send_item(OP_REGISTER, 4'd7, 32'hFFFF_FFFF);  // largest interval
        send_item(OP_REGISTER, 4'd7, 32'd1);          // already registered
        send_item(OP_REGISTER, 4'd7, 32'h0);          // param error wins
        send_item(OP_TICK, 4'd9, 32'hA5A5_5A5A);
        send_item(OP_REGISTER, 4'd0, 32'd6);
        send_item(OP_TICK, 4'd0, 32'h0);
        send_item(OP_REGISTER, 4'd2, 32'd1);          // half rounds to zero
        send_item(OP_FEED, 4'd2, 32'h0);
        send_item(OP_REGISTER, 4'd5, 32'h8000_0000);
        send_item(OP_FEED, 4'd0, 32'h0);
        send_item(OP_START, 4'd0, 32'h0);
        send_item(OP_START, 4'd6, 32'h1234_5678);     // start twice
        send_item(OP_REGISTER, 4'd4, 32'd10);         // register while running
        send_item(OP_FEED, 4'd2, 32'h0);
        send_item(OP_TICK, 4'd0, 32'h0);

        // Random: keep every source fed until the failure phase, then let
        // the patrol find one overdue and run on past the latched failure
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 3) begin
                tx_idle_pct <= 45;
                rx_idle_pct <= 24;
            end
            if (n == 2 * RANDOM_BEATS / 3) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            if (n == RX_HOLD_AT) begin
                rx_hold_go <= 1'b1;
            end
            if (n == DRAIN_PAUSE_AT || n == FAIL_PHASE_AT) begin
                wait_drained();
            end

            // a source that the next tick would make overdue gets fed first
            risk_src = -1;
            if (n < FAIL_PHASE_AT) begin
                for (int k = 0; k < SOURCES; k++) begin
                    elapsed = sb.clk_ms + 1 - sb.feed_tbl[k];
                    if (risk_src < 0 && sb.reg_tbl[k] && elapsed > sb.period_tbl[k]) begin
                        risk_src = k;
                    end
                end
            end

            pick = $urandom_range(99);
            if (risk_src >= 0) begin
                send_item(OP_FEED, SOURCE_W'(risk_src), $urandom);
            end else if (pick < ((n < FAIL_PHASE_AT) ? 58 : 65)) begin
                send_item(OP_TICK, SOURCE_W'($urandom_range(15)), $urandom);
            end else if (pick < 83) begin
                send_item(OP_FEED, SOURCE_W'($urandom_range(15)), $urandom);
            end else if (pick < 92) begin
                send_item(OP_REGISTER, SOURCE_W'($urandom_range(15)),
                          ($urandom_range(3) == 0) ? 32'h0 : $urandom);
            end else begin
                send_item(OP_START, SOURCE_W'($urandom_range(15)), $urandom);
            end
        end

        // Wind down: wait for owed reports, then check for any still missing
        s_valid <= 1'b0;
        w = 0;
        while (sb.pending() != 0 && w < END_WAIT_LIMIT) begin
            @(posedge aclk);
            w++;
        end
        repeat (20) @(posedge aclk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog on the run itself
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
design/mswd_pkg.sv
design/mswd_ctrl.sv
design/mswd_datapath.sv
design/multi_source_watchdog_monitor_unit.sv
sim/tb_top.sv
